@@ design/btcd_pkg.sv @@
// Package with the item types, codes and fixed constants of the track-to-channel demultiplexer.
package btcd_pkg;

    localparam int WORD_BYTES       = 4;
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int MAX_FAN_OUT_DEF  = 8;

    localparam int DATA_W     = 32;
    localparam int POS_W      = 5;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Positions at or beyond this limit read as zero.
    localparam int POS_LIMIT = (WORD_BYTES * 8 < DATA_W) ? WORD_BYTES * 8 : DATA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_LOG2 = 2'd1;

    localparam logic FUNC_MAP  = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    typedef struct packed {
        logic             func;
        logic [3:0]       map_channel;
        logic [2:0]       map_slot;
        logic [POS_W-1:0] track_pos;
        logic [DATA_W-1:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [3:0]        out_channel;
        logic [BYTE_W-1:0] channel_byte;
        logic              last;
    } t_out_item;

endpackage

@@ design/bit_track_channel_demux.sv @@
// Top level of the track-to-channel bit demultiplexer: map memory, accumulator memory, pipeline.
//
// Map items (func 0) write one track position into the map and finish in the cycle they are
// accepted. A data item (func 1) is swept over the channels in use, one channel per cycle: the
// sweep reads the channel's map row and its accumulator from two synchronous memories, and the
// next stage picks the fan-out bits from the word, merges them into the accumulator and writes
// it back. A data item therefore occupies the sweep until all channels in use (1 to 16) are
// issued; the sweep issues one channel per cycle, one accumulator read and one write back
// each, with the write forwarded to a read of the same channel that directly follows it. The
// next item is accepted in the cycle that issues the last channel of the current
// one, so items follow each other without gaps. On the word that completes a sequence
// the stage emits one byte per channel in use, one per cycle, channel 0 first, the last one
// flagged; a one-entry output register separates the result channel, and the pipeline only
// stalls while that register is full and not taken. Writing either configuration register
// clears all accumulators and starts a fresh sequence; map entries hold their value until
// rewritten and must be written before a data item reads them.
module bit_track_channel_demux
    import btcd_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int MAX_FAN_OUT  = MAX_FAN_OUT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SLOT_W     = (MAX_FAN_OUT > 1) ? $clog2(MAX_FAN_OUT) : 1;
    // Largest power of two not above MAX_FAN_OUT, as a log2.
    localparam int FAN_LG_MAX = $clog2(MAX_FAN_OUT + 1) - 1;

    typedef logic [MAX_FAN_OUT-1:0][POS_W-1:0] t_map_row;

    // Configuration registers and sequence position.
    logic [CFG_DATA_W-1:0] r_cfg_chans;
    logic [1:0]            r_cfg_fan;
    logic [2:0]            r_wis;

    // Memories.
    t_map_row          r_map_mem [MAX_CHANNELS];
    logic [BYTE_W-1:0] r_acc_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_acc_vld;

    // Channel sweep (issue stage).
    logic              r_seq_busy;
    logic [CH_W-1:0]   r_seq_ch;
    logic [CH_W-1:0]   r_seq_last;
    logic [DATA_W-1:0] r_seq_word;
    logic [2:0]        r_seq_base;
    logic [1:0]        r_seq_lg;
    logic              r_seq_emit;

    // Merge stage.
    logic              r_s2_valid;
    logic [CH_W-1:0]   r_s2_ch;
    logic              r_s2_last;
    logic [DATA_W-1:0] r_s2_word;
    logic [2:0]        r_s2_base;
    logic [1:0]        r_s2_lg;
    logic              r_s2_emit;
    t_map_row          r_map_rd;
    logic [BYTE_W-1:0] r_acc_rd;
    logic              r_acc_rd_vld;

    // Last accumulator write, kept for forwarding.
    logic              r_wr_en;
    logic [CH_W-1:0]   r_wr_ch;
    logic [BYTE_W-1:0] r_wr_data;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;

    logic              adv;
    logic              in_acc;
    logic              seq_free;
    logic [1:0]        eff_lg;
    logic [CH_W-1:0]   eff_last;
    logic              word_emit;
    logic [BYTE_W-1:0] acc_in;
    logic [BYTE_W-1:0] pick_bits;
    logic [BYTE_W-1:0] acc_new;
    logic [BYTE_W-1:0] wr_data;
    logic              map_ok;

    // The whole pipeline moves unless an emitted byte finds the output register blocked.
    assign adv      = !(r_s2_valid && r_s2_emit && r_out_valid && !i_out_ready);
    assign seq_free = !r_seq_busy || (r_seq_ch == r_seq_last);
    assign o_in_ready = adv && seq_free;
    assign in_acc   = i_in_valid && o_in_ready;

    always_comb begin
        if (r_cfg_fan > 2'(FAN_LG_MAX)) begin
            eff_lg = 2'(FAN_LG_MAX);
        end else begin
            eff_lg = r_cfg_fan;
        end
        if (r_cfg_chans == '0) begin
            eff_last = '0;
        end else if (r_cfg_chans > CFG_DATA_W'(MAX_CHANNELS)) begin
            eff_last = CH_W'(MAX_CHANNELS - 1);
        end else begin
            eff_last = CH_W'(r_cfg_chans - 1'b1);
        end
        // A sequence is complete after 8 >> lg words.
        word_emit = ({1'b0, r_wis} + 4'd1) >= (4'd8 >> eff_lg);
        map_ok = (32'(i_in_data.map_channel) < MAX_CHANNELS)
              && (32'(i_in_data.map_slot) < MAX_FAN_OUT);
    end

    // Sequence counter and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_chans <= CFG_DATA_W'(1);
            r_cfg_fan   <= '0;
            r_wis       <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_CHANNELS) begin
                r_cfg_chans <= i_cfg_data;
                r_wis       <= '0;
            end else if (i_cfg_index == CFG_FAN_LOG2) begin
                r_cfg_fan <= i_cfg_data[1:0];
                r_wis     <= '0;
            end
        end else if (in_acc && i_in_data.func == FUNC_DATA) begin
            r_wis <= word_emit ? 3'd0 : r_wis + 3'd1;
        end
    end

    // Map memory: one field of a row is written, one whole row is read per cycle while the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.func == FUNC_MAP && map_ok) begin
            r_map_mem[CH_W'(i_in_data.map_channel)][SLOT_W'(i_in_data.map_slot)]
                <= i_in_data.track_pos;
        end
        if (adv) begin
            r_map_rd <= r_map_mem[r_seq_ch];
        end
    end

    // Channel sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_busy <= 1'b0;
        end else if (adv) begin
            if (in_acc && i_in_data.func == FUNC_DATA) begin
                r_seq_busy <= 1'b1;
            end else if (seq_free) begin
                r_seq_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (in_acc && i_in_data.func == FUNC_DATA) begin
                r_seq_ch   <= '0;
                r_seq_last <= eff_last;
                r_seq_word <= i_in_data.data_word;
                r_seq_base <= 3'(r_wis << eff_lg);
                r_seq_lg   <= eff_lg;
                r_seq_emit <= word_emit;
            end else if (r_seq_busy && !seq_free) begin
                r_seq_ch <= r_seq_ch + 1'b1;
            end
        end
    end

    // Merge stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_seq_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_ch      <= r_seq_ch;
            r_s2_last    <= (r_seq_ch == r_seq_last);
            r_s2_word    <= r_seq_word;
            r_s2_base    <= r_seq_base;
            r_s2_lg      <= r_seq_lg;
            r_s2_emit    <= r_seq_emit;
            r_acc_rd     <= r_acc_mem[r_seq_ch];
            r_acc_rd_vld <= r_acc_vld[r_seq_ch];
        end
    end

    // Pick the fan-out bits of this channel and merge them, earliest bit at the MSB.
    always_comb begin
        logic [2:0] dst;
        if (r_wr_en && r_wr_ch == r_s2_ch) begin
            acc_in = r_wr_data;
        end else if (r_acc_rd_vld) begin
            acc_in = r_acc_rd;
        end else begin
            acc_in = '0;
        end
        pick_bits = '0;
        for (int j = 0; j < MAX_FAN_OUT; j++) begin
            dst = 3'd7 - 3'(r_s2_base + 3'(j));
            if (j < (1 << r_s2_lg) && 32'(r_map_rd[j]) < POS_LIMIT) begin
                pick_bits[dst] = r_s2_word[r_map_rd[j]];
            end
        end
        acc_new = acc_in | pick_bits;
        wr_data = r_s2_emit ? '0 : acc_new;
    end

    // Accumulator memory with valid bits; a cleared entry reads as zero.
    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid) begin
            r_acc_mem[r_s2_ch] <= wr_data;
        end
        if (adv) begin
            r_wr_ch   <= r_s2_ch;
            r_wr_data <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
            r_wr_en   <= 1'b0;
        end else if (i_cfg_we && (i_cfg_index == CFG_CHANNELS
                                  || i_cfg_index == CFG_FAN_LOG2)) begin
            r_acc_vld <= '0;
            r_wr_en   <= 1'b0;
        end else if (adv) begin
            r_wr_en <= r_s2_valid;
            if (r_s2_valid) begin
                r_acc_vld[r_s2_ch] <= 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_s2_valid && r_s2_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid && r_s2_emit) begin
            r_out.out_channel  <= 4'(r_s2_ch);
            r_out.channel_byte <= acc_new;
            r_out.last         <= r_s2_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // A new item is only taken when the sweep is idle or on its last channel.
    a_ready_sweep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!r_seq_busy || r_seq_ch == r_seq_last))
        else $error("input ready while the channel sweep is mid-word");

    // A write to the channel-count register leaves every accumulator cleared.
    a_cfg_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == CFG_CHANNELS) |=> (r_acc_vld == '0))
        else $error("accumulators not cleared by configuration write");

    // An emitted byte that moves on always shows up in the output register.
    a_emit_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_emit && adv) |=> o_out_valid)
        else $error("emitted byte lost before the output register");

    // The pipeline only stalls while a byte waits at the output.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |-> (o_out_valid && !i_out_ready))
        else $error("pipeline stalled without output back-pressure");
`endif

endmodule
